FILE: rtl/ials_pkg.sv
`default_nettype none

package ials_pkg;

   // list capacity used when the top level is not overridden
   localparam int DEPTH_DEFAULT = 64;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 7;
   localparam int COUNT_W     = 7;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND     = 3'd0,
      OP_REMOVE     = 3'd1,
      OP_INSERT     = 3'd2,
      OP_ERASE      = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_CLEAR      = 3'd5,
      OP_READ_FIRST = 3'd6,
      OP_READ_LAST  = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT,
      S_DRAIN,
      S_PLACE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/ials_mem.sv
`default_nettype none

module ials_mem #(
   parameter int  DEPTH = ials_pkg::DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic [AW-1:0]                 waddr,
   input  wire logic [ials_pkg::WORD_W-1:0]   wdata,
   input  wire logic                          re,
   input  wire logic [AW-1:0]                 raddr,
   output logic      [ials_pkg::WORD_W-1:0]   rdata
);

   logic [ials_pkg::WORD_W-1:0] store_ff [DEPTH];
   logic [ials_pkg::WORD_W-1:0] rdata_ff;

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/ials_ctrl.sv
`default_nettype none

module ials_ctrl #(
   parameter int  DEPTH = ials_pkg::DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1),
   localparam int PW    = (CW > ials_pkg::POS_W) ? CW : ials_pkg::POS_W
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire ials_pkg::op_type                     req_op,
   input  wire logic [ials_pkg::POS_W-1:0]           req_position,
   input  wire logic signed [ials_pkg::WORD_W-1:0]   req_value,
   output logic                                      req_ready,
   input  wire logic                                 res_take,
   output logic                                      res_valid,
   output ials_pkg::result_type                      res,
   output logic                                      mem_we,
   output logic [AW-1:0]                             mem_waddr,
   output logic [ials_pkg::WORD_W-1:0]               mem_wdata,
   output logic                                      mem_re,
   output logic [AW-1:0]                             mem_raddr,
   input  wire logic [ials_pkg::WORD_W-1:0]          mem_rdata
);

   ials_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   ials_pkg::result_type  res_ff, res_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         end_ff, end_in;
   logic [AW-1:0]         wr_addr_ff, wr_addr_in;
   logic                  up_ff, up_in;
   logic                  pend_ff, pend_in;
   logic signed [ials_pkg::WORD_W-1:0] val_ff, val_in;

   logic                  accept;
   logic [PW-1:0]         pos_x;
   logic [PW-1:0]         cnt_x;
   logic [AW-1:0]         pos_a;
   logic [CW-1:0]         cnt_m1;
   logic                  full;
   logic                  empty;

   // request decode
   ials_pkg::status_type  dec_status;
   logic [CW-1:0]         dec_count;
   ials_pkg::state_type   dec_next;
   logic                  dec_we;
   logic [AW-1:0]         dec_waddr;
   logic                  dec_re;
   logic [AW-1:0]         dec_raddr;
   logic [AW-1:0]         dec_ptr;
   logic [AW-1:0]         dec_end;
   logic                  dec_up;

   assign accept = req_valid && req_ready;
   assign pos_x  = PW'(req_position);
   assign cnt_x  = PW'(count_ff);
   assign pos_a  = pos_x[AW-1:0];
   assign cnt_m1 = count_ff - CW'(1);
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      dec_status = ials_pkg::ST_OK;
      dec_count  = count_ff;
      dec_next   = ials_pkg::S_DONE;
      dec_we     = 1'b0;
      dec_waddr  = count_ff[AW-1:0];
      dec_re     = 1'b0;
      dec_raddr  = pos_a;
      dec_ptr    = cnt_m1[AW-1:0];
      dec_end    = pos_a;
      dec_up     = 1'b1;
      case (req_op)
         ials_pkg::OP_APPEND: begin
            if (full) begin
               dec_status = ials_pkg::ST_FULL;
            end else begin
               dec_we    = 1'b1;
               dec_count = count_ff + CW'(1);
            end
         end
         ials_pkg::OP_REMOVE: begin
            if (empty) begin
               dec_status = ials_pkg::ST_RANGE;
            end else begin
               dec_count = cnt_m1;
            end
         end
         ials_pkg::OP_INSERT: begin
            if (pos_x > cnt_x) begin
               dec_status = ials_pkg::ST_RANGE;
            end else if (full) begin
               dec_status = ials_pkg::ST_FULL;
            end else begin
               dec_count = count_ff + CW'(1);
               if (pos_x == cnt_x) begin
                  // insert at the end is a plain write
                  dec_we    = 1'b1;
                  dec_waddr = pos_a;
               end else begin
                  // move entries up, from the last one down to the position
                  dec_next = ials_pkg::S_SHIFT;
               end
            end
         end
         ials_pkg::OP_ERASE: begin
            if (pos_x >= cnt_x) begin
               dec_status = ials_pkg::ST_RANGE;
            end else begin
               dec_count = cnt_m1;
               if (pos_x != PW'(cnt_m1)) begin
                  // move entries down, from position+1 up to the last one
                  dec_next = ials_pkg::S_SHIFT;
                  dec_ptr  = pos_a + AW'(1);
                  dec_end  = cnt_m1[AW-1:0];
                  dec_up   = 1'b0;
               end
            end
         end
         ials_pkg::OP_READ_AT: begin
            if (pos_x >= cnt_x) begin
               dec_status = ials_pkg::ST_RANGE;
            end else begin
               dec_re   = 1'b1;
               dec_next = ials_pkg::S_READ;
            end
         end
         ials_pkg::OP_CLEAR: begin
            dec_count = '0;
         end
         ials_pkg::OP_READ_FIRST: begin
            if (empty) begin
               dec_status = ials_pkg::ST_RANGE;
            end else begin
               dec_re    = 1'b1;
               dec_raddr = '0;
               dec_next  = ials_pkg::S_READ;
            end
         end
         ials_pkg::OP_READ_LAST: begin
            if (empty) begin
               dec_status = ials_pkg::ST_RANGE;
            end else begin
               dec_re    = 1'b1;
               dec_raddr = cnt_m1[AW-1:0];
               dec_next  = ials_pkg::S_READ;
            end
         end
         default: begin
            dec_status = ials_pkg::ST_RANGE;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ials_pkg::S_IDLE: begin
            if (accept) begin
               state_in = dec_next;
            end
         end
         ials_pkg::S_READ: begin
            state_in = ials_pkg::S_DONE;
         end
         ials_pkg::S_SHIFT: begin
            if (ptr_ff == end_ff) begin
               state_in = ials_pkg::S_DRAIN;
            end
         end
         ials_pkg::S_DRAIN: begin
            state_in = up_ff ? ials_pkg::S_PLACE : ials_pkg::S_DONE;
         end
         ials_pkg::S_PLACE: begin
            state_in = ials_pkg::S_DONE;
         end
         ials_pkg::S_DONE: begin
            if (res_take) begin
               state_in = accept ? dec_next : ials_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ials_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and memory port
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = dec_waddr;
      mem_wdata = req_value;
      mem_re    = 1'b0;
      mem_raddr = dec_raddr;
      case (state_ff)
         ials_pkg::S_IDLE: begin
            req_ready = 1'b1;
            mem_we    = accept && dec_we;
            mem_re    = accept && dec_re;
         end
         ials_pkg::S_READ: begin
         end
         ials_pkg::S_SHIFT: begin
            // read one entry ahead, write the one read in the last cycle
            mem_re    = 1'b1;
            mem_raddr = ptr_ff;
            mem_we    = pend_ff;
            mem_waddr = wr_addr_ff;
            mem_wdata = mem_rdata;
         end
         ials_pkg::S_DRAIN: begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_ff;
            mem_wdata = mem_rdata;
         end
         ials_pkg::S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = end_ff;
            mem_wdata = val_ff;
         end
         ials_pkg::S_DONE: begin
            res_valid = 1'b1;
            req_ready = res_take;
            mem_we    = accept && dec_we;
            mem_re    = accept && dec_re;
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      count_in   = count_ff;
      res_in     = res_ff;
      ptr_in     = ptr_ff;
      end_in     = end_ff;
      wr_addr_in = wr_addr_ff;
      up_in      = up_ff;
      pend_in    = pend_ff;
      val_in     = val_ff;
      if (accept) begin
         count_in          = dec_count;
         res_in.read_value = '0;
         res_in.status     = dec_status;
         res_in.count      = ials_pkg::COUNT_W'(dec_count);
         res_in.is_empty   = (dec_count == '0);
         ptr_in            = dec_ptr;
         end_in            = dec_end;
         up_in             = dec_up;
         val_in            = req_value;
         pend_in           = 1'b0;
      end else begin
         case (state_ff)
            ials_pkg::S_READ: begin
               res_in.read_value = mem_rdata;
            end
            ials_pkg::S_SHIFT: begin
               pend_in    = 1'b1;
               wr_addr_in = up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
               ptr_in     = up_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ials_pkg::S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      ptr_ff     <= ptr_in;
      end_ff     <= end_in;
      wr_addr_ff <= wr_addr_in;
      up_ff      <= up_in;
      val_ff     <= val_in;
   end

   assign res = res_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ials_pkg::S_IDLE && !accept) |-> !mem_we)
      else $error("memory write while idle");

   a_shift_dir: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ials_pkg::S_SHIFT) |-> (up_ff ? (ptr_ff >= end_ff) : (ptr_ff <= end_ff)))
      else $error("shift pointer passed its end");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ials_pkg::S_READ) |=> (state_ff == ials_pkg::S_DONE))
      else $error("read did not complete in one cycle");

endmodule

`default_nettype wire

FILE: rtl/indexed_array_list_engine_unit.sv
`default_nettype none

// ordered list of signed 32-bit words in a DEPTH-entry single-port-write memory.
// each request (kind in req_tuser) returns one response with the read value, a
// status (ok, out of range or empty, full), the new count and an empty flag; a
// failing request changes nothing, clear leaves the stored words in place.
// requests are handled one at a time. append, remove last, clear, insert at
// the end, erase of the last entry and any request that fails go straight to
// the response; read at, read first and read last first wait for the registered
// memory read. any other insert or erase moves the entries after the position
// through the memory's one read and one write port, one entry per cycle, the
// read running one entry ahead of the write; an insert then writes its word.
// the next request is taken once the response moves to the output register.
// the response sits in an output register, so a new request is taken while
// an earlier response waits for rsp_tready. no clearing pass after reset.
module indexed_array_list_engine_unit #(
   parameter int DEPTH = ials_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [6:0] position, [38:7] value, [39] zero
   input  wire logic [ials_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] req_type
   input  wire logic [ials_pkg::OP_W-1:0]            req_tuser,
   // response channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [31:0] read_value, [33:32] status, [40:34] count, [41] is_empty, [47:42] zero
   output logic [ials_pkg::RSP_TDATA_W-1:0]          rsp_tdata
);

   localparam int AW = $clog2(DEPTH);

   // request fields
   logic [ials_pkg::POS_W-1:0]         req_position;
   logic signed [ials_pkg::WORD_W-1:0] req_value;
   ials_pkg::op_type                   req_op;

   // controller to output register
   logic                  res_valid;
   logic                  res_take;
   ials_pkg::result_type  res;

   // memory port
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [ials_pkg::WORD_W-1:0]   mem_wdata;
   logic                          mem_re;
   logic [AW-1:0]                 mem_raddr;
   logic [ials_pkg::WORD_W-1:0]   mem_rdata;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   ials_pkg::result_type  rsp_data_ff, rsp_data_in;

   assign req_position = req_tdata[ials_pkg::POS_W-1:0];
   assign req_value    = signed'(req_tdata[ials_pkg::POS_W+ials_pkg::WORD_W-1:ials_pkg::POS_W]);
   assign req_op       = ials_pkg::op_type'(req_tuser);

   ials_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_op       (req_op),
      .req_position (req_position),
      .req_value    (req_value),
      .req_ready    (req_tready),
      .res_take     (res_take),
      .res_valid    (res_valid),
      .res          (res),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   ials_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // the finished response moves on when the output register is empty or draining
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_data_ff.is_empty,
                        rsp_data_ff.count,
                        rsp_data_ff.status,
                        rsp_data_ff.read_value};

endmodule

`default_nettype wire

FILE: tb/indexed_array_list_engine_unit_test.sv
`default_nettype none

module indexed_array_list_engine_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = ials_pkg::DEPTH_DEFAULT;
   // longest request is an insert that moves every entry, plus some margin
   localparam int DRAIN_CYCLES = LIST_DEPTH + 16;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PER_PHASE = 220;
   localparam int SCRIPT_ROWS = 27;

   // one row of the directed script; typed rows carry their own expected response
   typedef struct packed {
      ials_pkg::op_type                  op;
      logic [ials_pkg::POS_W-1:0]        pos;
      logic [ials_pkg::WORD_W-1:0]       val;
      logic [6:0]                        reps;
      logic                              typed;
      logic [ials_pkg::WORD_W-1:0]       rd;
      ials_pkg::status_type              st;
      logic [ials_pkg::COUNT_W-1:0]      cnt;
   } script_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // [6:0] position, [38:7] value, [39] zero
   logic [ials_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   // [2:0] req_type
   logic [ials_pkg::OP_W-1:0]        req_tuser = ials_pkg::OP_APPEND;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // [31:0] read_value, [33:32] status, [40:34] count, [41] is_empty, [47:42] zero
   logic [ials_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // predicted list contents and length
   logic [ials_pkg::WORD_W-1:0] list_words [LIST_DEPTH];
   int                          list_len = 0;

   // responses still owed by the block, oldest first
   ials_pkg::result_type pending_responses [$];

   int  error_count = 0;
   int  req_idle_pct = 13;
   int  rsp_idle_pct = 64;
   logic rsp_hold = 1'b0;
   event rsp_hold_go;

   script_row_type script [SCRIPT_ROWS];

   ials_pkg::result_type got_rsp;
   ials_pkg::result_type want_rsp;

   indexed_array_list_engine_unit #(
      .DEPTH(LIST_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // list behavior: applies one request to the predicted list and returns the
   // response the block owes for it
   // ---------------------------------------------------------------------------
   function automatic ials_pkg::result_type apply_list_request(ials_pkg::op_type op, int pos,
                                                               logic [ials_pkg::WORD_W-1:0] val);
      ials_pkg::result_type r;
      int                   i;
      r.read_value = '0;
      r.status = ials_pkg::ST_OK;
      case (op)
         ials_pkg::OP_APPEND: begin
            if (list_len >= LIST_DEPTH) begin
               r.status = ials_pkg::ST_FULL;
            end else begin
               list_words[list_len] = val;
               list_len++;
            end
         end
         ials_pkg::OP_REMOVE: begin
            if (list_len == 0) r.status = ials_pkg::ST_RANGE;
            else list_len--;
         end
         ials_pkg::OP_INSERT: begin
            // a bad position wins over a full list
            if (pos > list_len) begin
               r.status = ials_pkg::ST_RANGE;
            end else if (list_len >= LIST_DEPTH) begin
               r.status = ials_pkg::ST_FULL;
            end else begin
               for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = val;
               list_len++;
            end
         end
         ials_pkg::OP_ERASE: begin
            if (pos >= list_len) begin
               r.status = ials_pkg::ST_RANGE;
            end else begin
               for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         ials_pkg::OP_READ_AT: begin
            if (pos >= list_len) r.status = ials_pkg::ST_RANGE;
            else r.read_value = list_words[pos];
         end
         ials_pkg::OP_CLEAR: begin
            // stored words stay, only the length drops
            list_len = 0;
         end
         ials_pkg::OP_READ_FIRST: begin
            if (list_len == 0) r.status = ials_pkg::ST_RANGE;
            else r.read_value = list_words[0];
         end
         default: begin
            if (list_len == 0) r.status = ials_pkg::ST_RANGE;
            else r.read_value = list_words[list_len-1];
         end
      endcase
      r.count = list_len[ials_pkg::COUNT_W-1:0];
      r.is_empty = (list_len == 0);
      return r;
   endfunction

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // ---------------------------------------------------------------------------
   // request side: called at a falling edge, returns at the falling edge after
   // the request was taken; the prediction is made at the accepting edge
   // ---------------------------------------------------------------------------
   task automatic send_request(ials_pkg::op_type op, logic [ials_pkg::POS_W-1:0] pos,
                               logic [ials_pkg::WORD_W-1:0] val,
                               logic typed, ials_pkg::result_type typed_rsp);
      ials_pkg::result_type predicted;
      // random gaps before the request goes out
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, val, pos};
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_request(op, int'(pos), val);
      pending_responses.insert(pending_responses.size(), typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // random request kinds: mode 0 grows the list, mode 1 shrinks it, mode 2 mixes
   // ---------------------------------------------------------------------------
   function automatic ials_pkg::op_type pick_request_kind(int mode);
      int roll;
      int grow;
      int shrink;
      roll = $urandom_range(0, 99);
      grow = (mode == 0) ? 65 : (mode == 1) ? 20 : 38;
      shrink = (mode == 0) ? 12 : (mode == 1) ? 55 : 38;
      if (roll < grow) begin
         return ($urandom_range(0, 1) == 0) ? ials_pkg::OP_APPEND : ials_pkg::OP_INSERT;
      end else if (roll < grow + shrink) begin
         return ($urandom_range(0, 1) == 0) ? ials_pkg::OP_ERASE : ials_pkg::OP_REMOVE;
      end else if (roll < 98) begin
         case ($urandom_range(0, 2))
            0: return ials_pkg::OP_READ_AT;
            1: return ials_pkg::OP_READ_FIRST;
            default: return ials_pkg::OP_READ_LAST;
         endcase
      end
      return ials_pkg::OP_CLEAR;
   endfunction

   // mostly valid positions, some right at the edge, some anywhere in range
   function automatic logic [ials_pkg::POS_W-1:0] pick_position(ials_pkg::op_type op);
      int roll;
      int top;
      int edge_pos;
      roll = $urandom_range(0, 99);
      top = (op == ials_pkg::OP_INSERT) ? list_len : list_len - 1;
      edge_pos = (op == ials_pkg::OP_INSERT) ? list_len + 1 : list_len;
      if (edge_pos > LIST_DEPTH) edge_pos = LIST_DEPTH;
      if (roll < 75 && top >= 0) return ials_pkg::POS_W'($urandom_range(0, top));
      if (roll < 90) return ials_pkg::POS_W'(edge_pos);
      return ials_pkg::POS_W'($urandom_range(0, LIST_DEPTH));
   endfunction

   function automatic logic [ials_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------------

   // long hold-off, counted on rising edges so the receiver sees a steady flag
   initial begin
      forever begin
         @(rsp_hold_go);
         rsp_hold = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   // random back-pressure on the response channel
   always @(negedge clock) begin
      if (rsp_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // compare every taken response with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.read_value = rsp_tdata[31:0];
         got_rsp.status = ials_pkg::status_type'(rsp_tdata[33:32]);
         got_rsp.count = rsp_tdata[40:34];
         got_rsp.is_empty = rsp_tdata[41];
         if (pending_responses.size() == 0) begin
            note_error($sformatf("response with no request outstanding: tdata %h", rsp_tdata));
         end else begin
            want_rsp = pending_responses.pop_front();
            if (got_rsp.read_value !== want_rsp.read_value
                || got_rsp.status !== want_rsp.status
                || got_rsp.count !== want_rsp.count
                || got_rsp.is_empty !== want_rsp.is_empty) begin
               note_error($sformatf({"response mismatch: read_value exp %h got %h, ",
                                     "status exp %0d got %0d, count exp %0d got %0d, ",
                                     "is_empty exp %0b got %0b"},
                                    want_rsp.read_value, got_rsp.read_value,
                                    want_rsp.status, got_rsp.status,
                                    want_rsp.count, got_rsp.count,
                                    want_rsp.is_empty, got_rsp.is_empty));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   initial begin
      ials_pkg::result_type typed_rsp;
      ials_pkg::op_type     kind;
      int                   row;
      int                   k;
      int                   phase;
      int                   n;
      int                   issued;

      // op, pos, value, repeats, typed, read_value, status, count
      script = '{
         // everything that needs an entry fails on an empty list
         '{ials_pkg::OP_READ_FIRST, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd0},
         '{ials_pkg::OP_READ_LAST, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd0},
         '{ials_pkg::OP_REMOVE, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd0},
         '{ials_pkg::OP_ERASE, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd0},
         '{ials_pkg::OP_READ_AT, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd0},
         // insert past the end of an empty list
         '{ials_pkg::OP_INSERT, 7'd1, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd0},
         // extreme words, insert at the end acts as append
         '{ials_pkg::OP_INSERT, 7'd0, 32'h8000_0000, 7'd1, 1'b1, 32'd0, ials_pkg::ST_OK, 7'd1},
         '{ials_pkg::OP_APPEND, 7'd0, 32'h7fff_ffff, 7'd1, 1'b1, 32'd0, ials_pkg::ST_OK, 7'd2},
         '{ials_pkg::OP_INSERT, 7'd2, 32'hffff_ffff, 7'd1, 1'b1, 32'd0, ials_pkg::ST_OK, 7'd3},
         '{ials_pkg::OP_INSERT, 7'd1, 32'h0000_0000, 7'd1, 1'b1, 32'd0, ials_pkg::ST_OK, 7'd4},
         '{ials_pkg::OP_READ_AT, 7'd1, 32'd0, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_READ_FIRST, 7'd0, 32'd0, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_READ_LAST, 7'd0, 32'd0, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         // read at the count and at the capacity
         '{ials_pkg::OP_READ_AT, 7'd4, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd4},
         '{ials_pkg::OP_READ_AT, 7'd64, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd4},
         '{ials_pkg::OP_ERASE, 7'd0, 32'd0, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_ERASE, 7'd2, 32'd0, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_CLEAR, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_READ_LAST, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_RANGE, 7'd0},
         // fill to capacity, then every way of hitting a full list
         '{ials_pkg::OP_APPEND, 7'd0, 32'h5555_5555, 7'd64, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_APPEND, 7'd0, 32'd1, 7'd1, 1'b1, 32'd0, ials_pkg::ST_FULL, 7'd64},
         '{ials_pkg::OP_INSERT, 7'd64, 32'd1, 7'd1, 1'b1, 32'd0, ials_pkg::ST_FULL, 7'd64},
         '{ials_pkg::OP_INSERT, 7'd0, 32'd1, 7'd1, 1'b1, 32'd0, ials_pkg::ST_FULL, 7'd64},
         '{ials_pkg::OP_READ_AT, 7'd63, 32'd0, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         // longest shifts both ways
         '{ials_pkg::OP_ERASE, 7'd0, 32'd0, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_INSERT, 7'd0, 32'haaaa_aaaa, 7'd1, 1'b0, 32'd0, ials_pkg::ST_OK, 7'd0},
         '{ials_pkg::OP_CLEAR, 7'd0, 32'd0, 7'd1, 1'b1, 32'd0, ials_pkg::ST_OK, 7'd0}
      };

      // synchronous reset, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script
      for (row = 0; row < SCRIPT_ROWS; row++) begin
         typed_rsp.read_value = script[row].rd;
         typed_rsp.status = script[row].st;
         typed_rsp.count = script[row].cnt;
         typed_rsp.is_empty = (script[row].cnt == 0);
         for (k = 0; k < script[row].reps; k++) begin
            send_request(script[row].op, script[row].pos, script[row].val + k,
                         script[row].typed, typed_rsp);
         end
      end

      // random requests: slow receiver, then slow sender, then no gaps
      issued = 0;
      typed_rsp = '0;
      for (phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 64 : 0;
         rsp_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 13 : 0;
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // stall the response side while requests keep coming
            if (phase == 2 && n == 60) -> rsp_hold_go;
            kind = pick_request_kind((issued / 70) % 3);
            send_request(kind, pick_position(kind), pick_word(), 1'b0, typed_rsp);
            issued++;
         end
      end
      req_tvalid <= 1'b0;

      // wait for every owed response, then watch for strays
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
